// ===== hw/rtl/huffman_code_bit_packer_defines.svh =====
// Assertion macros for the checker of the bit packer.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define HCBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hcbp_pkg.sv =====
`default_nettype none

package hcbp_pkg;

    localparam int BYTE_W       = 8;
    localparam int ACC_W        = 7;
    localparam int PEND_W       = 3;
    localparam int SYM_W        = 8;
    localparam int CODE_FIELD_W = 32;
    localparam int LEN_FIELD_W  = 6;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FLUSH  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [SYM_W-1:0]        symbol;
        logic [CODE_FIELD_W-1:0] code_bits;
        logic [LEN_FIELD_W-1:0]  code_length;
    } t_in_req;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_out_req;

endpackage

`default_nettype wire

// ===== hw/rtl/huffman_code_bit_packer.sv =====
// Channel   Direction  Valid    Stall    Payload
// request   in         i_valid  o_stall  i_req  (kind, symbol, code_bits, code_length)
// result    out        o_valid  i_stall  o_res  (out_byte, last)
//
// A load request writes the code table when taken. An encode request reads the table
// (S_LOOK), then S_EMIT sends each complete byte through the single byte-wide output
// register. A flush with bits pending sends them as one padded byte, else does nothing.
// Reset is synchronous and clears the accumulator; the code table is not cleared.
// A stall on the result channel holds the byte and pauses the emitting sequence.
`default_nettype none

module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_req  i_req,
    output logic          o_stall,
    output logic          o_valid,
    output t_out_req      o_res,
    input  wire logic     i_stall
);

    // Codes longer than the input field cannot be loaded, so the table holds the lesser.
    localparam int LEN_LIM = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
    localparam int LW      = $clog2(LEN_LIM + 1);
    localparam int ENTRY_W = LEN_LIM + LW;
    localparam int AW      = $clog2(SYMBOL_COUNT);
    // The working word holds up to seven pending bits followed by one full code.
    localparam int COMB_W  = ACC_W + LEN_LIM;
    localparam int TW      = $clog2(COMB_W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [PEND_W-1:0]   r_pend, n_pend;
    logic [COMB_W-1:0]   r_comb, n_comb;
    logic [TW-1:0]       r_total, n_total;
    logic                r_out_valid, n_out_valid;
    t_out_req            r_out, n_out;

    logic                accept;
    logic                sym_ok;
    logic [AW-1:0]       addr;

    // Load path: saturate the length and clear code bits above it.
    logic [LEN_FIELD_W-1:0] ld_len6;
    logic [LEN_LIM-1:0]     ld_word;
    logic                   ram_we;
    logic                   ram_re;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [LEN_LIM-1:0]     rd_word;
    logic [LW-1:0]          rd_len;

    // Emit path.
    logic                   out_free;
    logic [TW-1:0]          emit_shift;
    logic [COMB_W-1:0]      emit_word;
    logic [TW-1:0]          rem_total;
    logic [BYTE_W-1:0]      rem_mask;

    assign accept  = i_valid && !o_stall;
    assign sym_ok  = (int'(i_req.symbol) < SYMBOL_COUNT);
    assign addr    = i_req.symbol[AW-1:0];

    assign ld_len6 = (i_req.code_length > LEN_FIELD_W'(LEN_LIM)) ?
                     LEN_FIELD_W'(LEN_LIM) : i_req.code_length;

    always_comb begin
        for (int i = 0; i < LEN_LIM; i++) begin
            ld_word[i] = i_req.code_bits[i] && (LEN_FIELD_W'(i) < ld_len6);
        end
    end

    assign ram_we = accept && (i_req.kind == KIND_LOAD) && sym_ok;
    assign ram_re = accept && (i_req.kind == KIND_ENCODE) && sym_ok;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_code_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata ({ld_len6[LW-1:0], ld_word}),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    assign rd_word = ram_rdata[LEN_LIM-1:0];
    assign rd_len  = ram_rdata[ENTRY_W-1:LEN_LIM];

    // The oldest complete byte sits just above the bits still to be sent.
    assign out_free   = !r_out_valid || !i_stall;
    assign emit_shift = r_total - TW'(BYTE_W);
    assign emit_word  = r_comb >> emit_shift;
    assign rem_total  = emit_shift;
    assign rem_mask   = (BYTE_W'(1) << rem_total[PEND_W-1:0]) - BYTE_W'(1);

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_comb      = r_comb;
        n_total     = r_total;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.kind)
                        KIND_ENCODE: begin
                            if (sym_ok) begin
                                n_state = S_LOOK;
                            end
                        end
                        KIND_FLUSH: begin
                            // Pending bits go out left-aligned in a single padded byte.
                            if (r_pend != '0) begin
                                n_comb  = COMB_W'(r_acc) << (4'(BYTE_W) - 4'(r_pend));
                                n_total = TW'(BYTE_W);
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                            // Loads finish with the table write; the unused kind does nothing.
                        end
                    endcase
                end
            end
            S_LOOK: begin
                if (rd_len == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_comb  = (COMB_W'(r_acc) << rd_len) | COMB_W'(rd_word);
                    n_total = TW'(r_pend) + TW'(rd_len);
                    if ((TW'(r_pend) + TW'(rd_len)) < TW'(BYTE_W)) begin
                        n_acc   = n_comb[ACC_W-1:0];
                        n_pend  = n_total[PEND_W-1:0];
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.out_byte = emit_word[BYTE_W-1:0];
                    n_out.last     = (rem_total < TW'(BYTE_W));
                    n_total        = rem_total;
                    if (rem_total < TW'(BYTE_W)) begin
                        n_acc   = r_comb[ACC_W-1:0] & rem_mask[ACC_W-1:0];
                        n_pend  = rem_total[PEND_W-1:0];
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_comb  <= n_comb;
        r_total <= n_total;
        r_out   <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/hcbp_ram.sv =====
`default_nettype none

// Simple dual-port RAM with one write port and one registered read port.
module hcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/hcbp_checker.sv =====
`default_nettype none

`include "huffman_code_bit_packer_defines.svh"

module hcbp_checker
    import hcbp_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_valid,
    input wire t_in_req  i_req,
    input wire logic     o_stall,
    input wire logic     o_valid,
    input wire t_out_req o_res,
    input wire logic     i_stall
);

    `HCBP_ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")
    `HCBP_ASSERT_NEXT(a_out_payload_held, i_clk, i_rst_n, o_valid && i_stall, $stable(o_res), "stalled result changed")
    // A byte that is not the last of its request means the request is still in progress.
    `HCBP_ASSERT_NOW(a_busy_mid_request, i_clk, i_rst_n, o_valid && !o_res.last, o_stall, "new request taken before all bytes were sent")
    // Loads complete in the cycle they are taken.
    `HCBP_ASSERT_NEXT(a_load_one_cycle, i_clk, i_rst_n, i_valid && !o_stall && (i_req.kind == KIND_LOAD), !o_stall, "load kept the block busy")

endmodule

bind huffman_code_bit_packer hcbp_checker u_checker (.*);

`default_nettype wire
